/* rtl/core/alld_pkg.sv */
// Shared types and constants of the affinity least-loaded dispatcher.
`default_nettype none
package alld_pkg;

  // Fixed field widths of the stream and register interfaces.
  localparam int ORIGIN_W  = 10;
  localparam int DONE_W    = 4;
  localparam int CHOSEN_W  = 4;
  localparam int WC_W      = 5;
  localparam int IMB_W     = 8;
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_WORKER_COUNT  = 1'b0;
  localparam logic REG_MAX_IMBALANCE = 1'b1;

  localparam logic [WC_W-1:0]  WC_RESET  = 5'd16;
  localparam logic [IMB_W-1:0] IMB_RESET = 8'd4;

  // Operation codes carried in tuser bit 0.
  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_DONE     = 1'b1;

  typedef struct packed {
    logic [WC_W-1:0]  worker_count;
    logic [IMB_W-1:0] max_imbalance;
  } alld_cfg_t;

endpackage
`default_nettype wire

/* rtl/core/alld_addsub.sv */
// Shared adder and subtractor used for the load compares, the threshold sum and the count updates.
`default_nettype none
module alld_addsub #(
  parameter int W = 17
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic      [W:0]   sum
);

  // With sub set, the top bit is the carry out: high when a is not below b.
  assign sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};

endmodule
`default_nettype wire

/* rtl/core/alld_cfg.sv */
// Configuration registers behind the APB-style port.
`default_nettype none
module alld_cfg
  import alld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output alld_cfg_t               cfg
);

  logic reg_sel;

  // Registers sit on a four-byte pitch, so bit 2 alone picks one.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.worker_count  <= WC_RESET;
      cfg.max_imbalance <= IMB_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_WORKER_COUNT:  cfg.worker_count  <= pwdata[WC_W-1:0];
        REG_MAX_IMBALANCE: cfg.max_imbalance <= pwdata[IMB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WORKER_COUNT:  prdata = {{(PDATA_W-WC_W){1'b0}}, cfg.worker_count};
      REG_MAX_IMBALANCE: prdata = {{(PDATA_W-IMB_W){1'b0}}, cfg.max_imbalance};
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/affinity_least_loaded_dispatcher_core.sv */
// Dispatch over n workers: a serial counter scan through the load memory finds the least loaded,
// then a dispatch with an origin passes the threshold, affinity and compare steps before the result.
// Input ready returns as the result turns valid; a new result also waits on a stalled one.
// A completion passes through the decrement state only; a single-worker dispatch skips the scan.
// After reset a clearing pass over max(ORIGIN_SLOTS, MAX_WORKERS) addresses empties both memories
// with the input held not ready; configuration writes are taken throughout.
`default_nettype none
module affinity_least_loaded_dispatcher_core
  import alld_pkg::*;
#(
  parameter int MAX_WORKERS  = 16,
  parameter int ORIGIN_SLOTS = 1024,
  parameter int COUNT_WIDTH  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // origin_id[9:0], done_worker[13:10], zero pad
  input  wire logic [S_TUSER_W-1:0] s_tuser,  // opcode[0], has_origin[1]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata   // chosen_worker[3:0], zero pad
);

  localparam int WIDX   = $clog2(MAX_WORKERS);
  localparam int NW     = $clog2(MAX_WORKERS + 1);
  localparam int IW     = (NW > DONE_W) ? NW : DONE_W;
  localparam int SW     = $clog2(ORIGIN_SLOTS);
  localparam int AW     = ((COUNT_WIDTH > IMB_W) ? COUNT_WIDTH : IMB_W) + 1;
  localparam int AE_W   = WIDX + 1;
  localparam int CLR_N  = (ORIGIN_SLOTS > MAX_WORKERS) ? ORIGIN_SLOTS : MAX_WORKERS;
  localparam int CLW    = $clog2(CLR_N);
  localparam int RSH    = ORIGIN_W + SW;
  localparam int RCP    = ((1 << RSH) + ORIGIN_SLOTS - 1) / ORIGIN_SLOTS;
  localparam int RCP_W  = ORIGIN_W + 2;
  localparam int PROD_W = ORIGIN_W + RCP_W;
  localparam int STEP_W = 2;

  typedef enum logic [2:0] {
    CLEAR, IDLE, SCAN, THRESH, AFF, CMP, INC, DEC
  } state_t;

  alld_cfg_t cfg;

  alld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t                state;
  logic [CLW-1:0]        clr;
  logic [NW-1:0]         idx;
  logic [AW-1:0]         min_load;
  logic [AW-1:0]         cur;
  logic [AW-1:0]         thr;
  logic [WIDX-1:0]       chosen;
  logic                  single;
  logic                  has_org;
  logic [ORIGIN_W-1:0]   origin_q;
  logic [ORIGIN_W-1:0]   rq;
  logic [SW-1:0]         rred;
  logic [STEP_W-1:0]     rstep;

  logic [NW-1:0]         n;
  logic [7:0]            wc8;
  logic [IW-1:0]         done_ext;
  logic                  done_lt;
  logic                  accept;
  logic                  out_stall;
  logic [NW-1:0]         km1;
  logic [IW-1:0]         chosen_ext;
  logic                  rdone;
  logic [PROD_W-1:0]     rprod;
  logic [ORIGIN_W-1:0]   rback;
  logic [ORIGIN_W-1:0]   rrem;
  logic [SW-1:0]         slot;
  logic [WIDX-1:0]       rem;
  logic                  rem_ok;

  logic [AW-1:0]         ua;
  logic [AW-1:0]         ub;
  logic                  usub;
  logic [AW:0]           usum;

  logic [COUNT_WIDTH-1:0] cnt_mem [MAX_WORKERS];
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic [WIDX-1:0]        cnt_raddr;
  logic                   cnt_we;
  logic [WIDX-1:0]        cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;

  logic [AE_W-1:0]        aff_mem [ORIGIN_SLOTS];
  logic [AE_W-1:0]        aff_rdata;
  logic                   aff_we;
  logic [SW-1:0]          aff_waddr;
  logic [AE_W-1:0]        aff_wdata;

  alld_addsub #(.W(AW)) u_addsub (
    .a   (ua),
    .b   (ub),
    .sub (usub),
    .sum (usum)
  );

  // A worker count of zero acts as one; one above the built maximum is clipped.
  always_comb begin
    wc8 = {3'b000, cfg.worker_count};
    if (wc8 == 8'd0) begin
      n = NW'(1);
    end else if (wc8 > 8'(MAX_WORKERS)) begin
      n = NW'(MAX_WORKERS);
    end else begin
      n = wc8[NW-1:0];
    end
  end

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == IDLE);
  assign done_ext   = IW'(s_tdata[ORIGIN_W +: DONE_W]);
  assign done_lt    = done_ext < IW'(n);
  assign out_stall  = m_tvalid && !m_tready;
  assign km1        = idx - NW'(1);
  assign chosen_ext = IW'(chosen);

  // Origin slot by reciprocal multiplication: the quotient is registered first, then the remainder,
  // both well inside the counter scan.
  assign rdone = (rstep == STEP_W'(2));
  assign rprod = PROD_W'(origin_q) * PROD_W'(RCP);
  assign rback = ORIGIN_W'(rq * ORIGIN_SLOTS);
  assign rrem  = origin_q - rback;
  assign slot  = rred;

  assign rem    = aff_rdata[WIDX-1:0];
  assign rem_ok = aff_rdata[WIDX] && (NW'(rem) < n);

  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    case (state)
      SCAN: begin
        ua   = AW'(cnt_rdata);
        ub   = min_load;
        usub = 1'b1;
      end
      THRESH: begin
        ua = min_load;
        ub = AW'(cfg.max_imbalance);
      end
      CMP: begin
        ua   = AW'(cnt_rdata);
        ub   = thr;
        usub = 1'b1;
      end
      INC: begin
        ua = cur;
        ub = AW'(1);
      end
      DEC: begin
        ua   = AW'(cnt_rdata);
        ub   = AW'(1);
        usub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state)
      IDLE:    cnt_raddr = done_ext[WIDX-1:0];
      SCAN:    cnt_raddr = idx[WIDX-1:0];
      AFF:     cnt_raddr = rem;
      default: cnt_raddr = chosen;
    endcase
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = chosen;
    cnt_wdata = usum[COUNT_WIDTH-1:0];
    aff_we    = 1'b0;
    aff_waddr = slot;
    aff_wdata = {1'b1, chosen};
    case (state)
      CLEAR: begin
        cnt_we    = {1'b0, clr} < (CLW+1)'(MAX_WORKERS);
        cnt_waddr = clr[WIDX-1:0];
        cnt_wdata = '0;
        aff_we    = {1'b0, clr} < (CLW+1)'(ORIGIN_SLOTS);
        aff_waddr = clr[SW-1:0];
        aff_wdata = '0;
      end
      INC: begin
        // The count saturates at all ones; a single-worker dispatch writes nothing.
        cnt_we = !single && !out_stall && !usum[COUNT_WIDTH];
        aff_we = !single && !out_stall && has_org;
      end
      DEC: cnt_we = usum[AW];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (aff_we) begin
      aff_mem[aff_waddr] <= aff_wdata;
    end
    aff_rdata <= aff_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr      <= '0;
      rstep    <= STEP_W'(2);
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != INC) begin
        m_tvalid <= 1'b0;
      end
      if (state != IDLE && !rdone) begin
        if (rstep == '0) begin
          rq <= ORIGIN_W'(rprod >> RSH);
        end else begin
          rred <= SW'(rrem);
        end
        rstep <= rstep + STEP_W'(1);
      end
      case (state)
        CLEAR: begin
          clr <= clr + CLW'(1);
          if (clr == CLW'(CLR_N - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            if (s_tuser[0] == OP_DONE) begin
              // A completion for a worker outside the active set is dropped here.
              if (done_lt) begin
                chosen <= done_ext[WIDX-1:0];
                state  <= DEC;
              end
            end else begin
              has_org  <= s_tuser[1];
              origin_q <= s_tdata[ORIGIN_W-1:0];
              rstep    <= '0;
              idx      <= '0;
              if (n == NW'(1)) begin
                single <= 1'b1;
                chosen <= '0;
                state  <= INC;
              end else begin
                single <= 1'b0;
                state  <= SCAN;
              end
            end
          end
        end
        SCAN: begin
          // Read data is registered behind the address, so step k judges worker k-1.
          if (idx == NW'(1)) begin
            min_load <= AW'(cnt_rdata);
            cur      <= AW'(cnt_rdata);
            chosen   <= '0;
          end else if (idx != '0 && !usum[AW]) begin
            min_load <= AW'(cnt_rdata);
            cur      <= AW'(cnt_rdata);
            chosen   <= km1[WIDX-1:0];
          end
          if (idx == n) begin
            state <= has_org ? THRESH : INC;
          end else begin
            idx <= idx + NW'(1);
          end
        end
        THRESH: begin
          if (rdone) begin
            thr   <= usum[AW-1:0];
            state <= AFF;
          end
        end
        AFF: begin
          state <= rem_ok ? CMP : INC;
        end
        CMP: begin
          if (!usum[AW]) begin
            chosen <= rem;
            cur    <= AW'(cnt_rdata);
          end
          state <= INC;
        end
        INC: begin
          if (!out_stall) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(M_TDATA_W-CHOSEN_W){1'b0}}, chosen_ext[CHOSEN_W-1:0]};
            state    <= IDLE;
          end
        end
        DEC: begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/alld_checker.sv */
// Port-level checks on the dispatcher, bound to the dispatcher core module.
`default_nettype none
module alld_checker
  import alld_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TUSER_W-1:0] s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // Reset empties the output and starts the clearing pass, so no beat is taken.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s_tready))
    else $error("output valid or input ready just after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or vanished");

  // Every dispatch beat keeps the block busy for at least the following cycle.
  a_dispatch_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0] == OP_DISPATCH) |=> !s_tready)
    else $error("input ready straight after a dispatch beat");

  a_result_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:CHOSEN_W] == '0))
    else $error("result padding bits not zero");

endmodule

bind affinity_least_loaded_dispatcher_core alld_checker u_alld_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
